@@ hdl/keypad_digit_entry_display_top_macros.svh @@
// Assertion macros for the keypad digit entry RTL.
// Included by kde_keypad, which checks its own logic; needs clk and rst in scope.
`ifndef KEYPAD_DIGIT_ENTRY_DISPLAY_TOP_MACROS_SVH
`define KEYPAD_DIGIT_ENTRY_DISPLAY_TOP_MACROS_SVH

// Checked at every edge outside reset.
`define KDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/kde_pkg.sv @@
// Shared types, constants and decode functions for the keypad digit entry block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package kde_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int TICK_W     = 10;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SETTLE   = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_BUZZER   = 2'd2;
  localparam logic [1:0] REG_REFRESH  = 2'd3;

  localparam logic [3:0] MAX_DIGIT_KEY = 4'd9;

  typedef enum logic [2:0] {
    PH_PRESS   = 3'd0,
    PH_PDEB    = 3'd1,
    PH_BUZZ    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_RDEB    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] buzzer_ticks;
    logic [TICK_W-1:0] refresh_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       buzzer_on;
    logic       key_event;
    logic [3:0] key_code;
  } key_out_t;

  typedef logic [NUM_DIGITS-1:0][3:0] digit_arr_t;

  // Returns {hit, column}: hit only when exactly one column is low.
  function automatic logic [2:0] decode_cols(input logic [3:0] cols);
    logic [2:0] r;
    case (cols)
      4'h7:    r = {1'b1, 2'd0};
      4'hB:    r = {1'b1, 2'd1};
      4'hD:    r = {1'b1, 2'd2};
      4'hE:    r = {1'b1, 2'd3};
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] k;
    case ({row, col})
      4'h0:    k = 4'd1;
      4'h1:    k = 4'd2;
      4'h2:    k = 4'd3;
      4'h3:    k = 4'd10;
      4'h4:    k = 4'd4;
      4'h5:    k = 4'd5;
      4'h6:    k = 4'd6;
      4'h7:    k = 4'd11;
      4'h8:    k = 4'd7;
      4'h9:    k = 4'd8;
      4'hA:    k = 4'd9;
      4'hB:    k = 4'd12;
      4'hC:    k = 4'd14;
      4'hD:    k = 4'd0;
      4'hE:    k = 4'd15;
      default: k = 4'd13;
    endcase
    return k;
  endfunction

  // Segments a..g with a in bit 6; codes above nine are blank.
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'b11111100;
      4'd1:    p = 8'b01100000;
      4'd2:    p = 8'b11011010;
      4'd3:    p = 8'b11110010;
      4'd4:    p = 8'b01100110;
      4'd5:    p = 8'b10110110;
      4'd6:    p = 8'b10111110;
      4'd7:    p = 8'b11100000;
      4'd8:    p = 8'b11111110;
      4'd9:    p = 8'b11110110;
      default: p = 8'b00000000;
    endcase
    p = p & 8'hFE;
    return p[7:1];
  endfunction

endpackage

@@ hdl/kde_keypad.sv @@
// Keypad scan state machine, debounce, buzzer timer and the digit store.
// Depends on kde_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "keypad_digit_entry_display_top_macros.svh"

module kde_keypad (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [3:0]          col_levels,
  input  kde_pkg::cfg_t       cfg,
  output kde_pkg::key_out_t   key_out,
  output kde_pkg::digit_arr_t digit_store
);

  kde_pkg::phase_t           phase, phase_next;
  logic [1:0]                current_row, current_row_next;
  logic [kde_pkg::TICK_W-1:0] wait_count, wait_count_next;
  logic [kde_pkg::TICK_W-1:0] buzz_count, buzz_count_next;
  logic [3:0]                found_key, found_key_next;
  kde_pkg::digit_arr_t       digit_store_next;

  logic [kde_pkg::TICK_W-1:0] wait_inc;
  logic                      settle_done, debounce_done;
  logic [2:0]                col_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= kde_pkg::PH_PRESS;
      current_row <= 2'd0;
      wait_count  <= '0;
      buzz_count  <= '0;
      found_key   <= 4'd0;
      digit_store <= '0;
    end else if (adv) begin
      phase       <= phase_next;
      current_row <= current_row_next;
      wait_count  <= wait_count_next;
      buzz_count  <= buzz_count_next;
      found_key   <= found_key_next;
      digit_store <= digit_store_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    current_row_next = current_row;
    wait_count_next  = wait_count;
    buzz_count_next  = buzz_count;
    found_key_next   = found_key;
    digit_store_next = digit_store;

    key_out.row_drive = ~(4'b1000 >> current_row);
    key_out.buzzer_on = 1'b0;
    key_out.key_event = 1'b0;
    key_out.key_code  = 4'd0;

    // The count restarts in the tick the limit is reached; zero acts like one.
    wait_inc      = wait_count + 1'b1;
    settle_done   = ({1'b0, wait_count} + 11'd1) >= {1'b0, cfg.settle_ticks};
    debounce_done = ({1'b0, wait_count} + 11'd1) >= {1'b0, cfg.debounce_ticks};
    col_dec       = kde_pkg::decode_cols(col_levels);

    case (phase)
      kde_pkg::PH_PDEB: begin
        if (debounce_done) begin
          wait_count_next   = '0;
          key_out.key_event = 1'b1;
          key_out.key_code  = found_key;
          if (found_key <= kde_pkg::MAX_DIGIT_KEY) begin
            for (int i = 0; i < kde_pkg::NUM_DIGITS - 1; i++) begin
              digit_store_next[i] = digit_store[i+1];
            end
            digit_store_next[kde_pkg::NUM_DIGITS-1] = found_key;
            buzz_count_next = cfg.buzzer_ticks;
            phase_next      = kde_pkg::PH_BUZZ;
          end else begin
            current_row_next = 2'd0;
            phase_next       = kde_pkg::PH_RELEASE;
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
      kde_pkg::PH_BUZZ: begin
        key_out.buzzer_on = 1'b1;
        if (buzz_count <= 10'd1) begin
          buzz_count_next  = '0;
          wait_count_next  = '0;
          current_row_next = 2'd0;
          phase_next       = kde_pkg::PH_RELEASE;
        end else begin
          buzz_count_next = buzz_count - 1'b1;
        end
      end
      kde_pkg::PH_RELEASE: begin
        if (settle_done) begin
          wait_count_next = '0;
          if (col_dec[2]) begin
            phase_next = kde_pkg::PH_RDEB;
          end else if (current_row == 2'd3) begin
            current_row_next = 2'd0;
            phase_next       = kde_pkg::PH_PRESS;
          end else begin
            current_row_next = current_row + 1'b1;
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
      kde_pkg::PH_RDEB: begin
        // A key seen while waiting for release only restarts the release scan.
        if (debounce_done) begin
          wait_count_next  = '0;
          current_row_next = 2'd0;
          phase_next       = kde_pkg::PH_RELEASE;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      default: begin
        phase_next = kde_pkg::PH_PRESS;
        if (settle_done) begin
          wait_count_next = '0;
          if (col_dec[2]) begin
            found_key_next = kde_pkg::key_lookup(current_row, col_dec[1:0]);
            phase_next     = kde_pkg::PH_PDEB;
          end else begin
            current_row_next = current_row + 1'b1;
          end
        end else begin
          wait_count_next = wait_inc;
        end
      end
    endcase
  end

  `KDE_ASSERT(a_row_one_cold, $onehot(~key_out.row_drive), "row drive not one-cold")
  `KDE_ASSERT(a_event_in_debounce, key_out.key_event |-> (phase == kde_pkg::PH_PDEB),
              "key event outside press debounce")
  `KDE_ASSERT(a_digit_starts_buzz,
              (adv && key_out.key_event && key_out.key_code <= kde_pkg::MAX_DIGIT_KEY) |=>
              (phase == kde_pkg::PH_BUZZ &&
               digit_store[kde_pkg::NUM_DIGITS-1] == $past(key_out.key_code)),
              "digit key did not enter store and start buzzer")

endmodule

@@ hdl/kde_display.sv @@
// Display multiplexer: refresh timer, digit rotation and segment decode.
// Depends on kde_pkg.
`timescale 1ns / 1ps

module kde_display (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [9:0]          refresh_ticks,
  input  kde_pkg::digit_arr_t digit_store,
  output logic [6:0]          segments,
  output logic [3:0]          digit_enable
);

  logic [9:0]                refresh_count, refresh_count_next;
  logic [kde_pkg::DIG_W-1:0] active_digit, active_digit_next;
  logic                      refresh_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_count <= '0;
      active_digit  <= '0;
    end else if (adv) begin
      refresh_count <= refresh_count_next;
      active_digit  <= active_digit_next;
    end
  end

  always_comb begin
    refresh_done = ({1'b0, refresh_count} + 11'd1) >= {1'b0, refresh_ticks};
    if (refresh_done) begin
      refresh_count_next = '0;
      if (32'(active_digit) == kde_pkg::NUM_DIGITS - 1) begin
        active_digit_next = '0;
      end else begin
        active_digit_next = active_digit + 1'b1;
      end
    end else begin
      refresh_count_next = refresh_count + 1'b1;
      active_digit_next  = active_digit;
    end

    // Only the first four digits have an enable line; the rest stay blank.
    for (int i = 0; i < 4; i++) begin
      digit_enable[i] = (i < kde_pkg::NUM_DIGITS) && (32'(active_digit) == i);
    end
    if (32'(active_digit) < 4) begin
      segments = kde_pkg::seg_pattern(digit_store[active_digit]);
    end else begin
      segments = 7'd0;
    end
  end

endmodule

@@ hdl/keypad_digit_entry_display_top.sv @@
// Keypad scanner with 4-digit entry and multiplexed seven-segment display, top level.
// Once a tick is accepted on the input, its result word is ready on the output in the
// next cycle. The output register takes a new word in every cycle that the consumer
// accepts or the register is empty, so one tick per clock is sustained. Each input
// word is one timing tick carrying the sampled column levels; each output word gives
// row drive, segments, digit enable, buzzer and any accepted key for that tick. Timing
// registers are written over the APB port; the user must keep the stream idle, unenforced.
`timescale 1ns / 1ps

module keypad_digit_entry_display_top (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] col_levels, [7:4] zero
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] row_drive, [10:4] segments, [14:11] digit_enable,
                                 // [15] buzzer_on, [16] key_event, [20:17] key_code,
                                 // [23:21] zero
);

  kde_pkg::cfg_t       cfg;
  kde_pkg::key_out_t   key_out;
  kde_pkg::digit_arr_t digit_store;
  logic [6:0]          segments;
  logic [3:0]          digit_enable;
  logic                adv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks   <= 10'd5;
      cfg.debounce_ticks <= 10'd50;
      cfg.buzzer_ticks   <= 10'd100;
      cfg.refresh_ticks  <= 10'd5;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        kde_pkg::REG_SETTLE:   cfg.settle_ticks   <= pwdata[9:0];
        kde_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[9:0];
        kde_pkg::REG_BUZZER:   cfg.buzzer_ticks   <= pwdata[9:0];
        kde_pkg::REG_REFRESH:  cfg.refresh_ticks  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kde_pkg::REG_SETTLE:   prdata = {22'd0, cfg.settle_ticks};
      kde_pkg::REG_DEBOUNCE: prdata = {22'd0, cfg.debounce_ticks};
      kde_pkg::REG_BUZZER:   prdata = {22'd0, cfg.buzzer_ticks};
      kde_pkg::REG_REFRESH:  prdata = {22'd0, cfg.refresh_ticks};
      default:               prdata = 32'd0;
    endcase
  end

  assign s_tready = ~m_tvalid | m_tready;
  assign adv      = s_tvalid & s_tready;

  kde_keypad u_keypad (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .col_levels  (s_tdata[3:0]),
    .cfg         (cfg),
    .key_out     (key_out),
    .digit_store (digit_store)
  );

  kde_display u_display (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .refresh_ticks (cfg.refresh_ticks),
    .digit_store   (digit_store),
    .segments      (segments),
    .digit_enable  (digit_enable)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'd0, key_out.key_code, key_out.key_event, key_out.buzzer_on,
                  digit_enable, segments, key_out.row_drive};
    end
  end

endmodule
